// ===== rtl/turtle_grid_plotter_core_assert.svh =====
// assertion macros shared by the turtle grid plotter modules
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef TURTLE_GRID_PLOTTER_CORE_ASSERT_SVH
`define TURTLE_GRID_PLOTTER_CORE_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define TGP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tgp assertion failed");

// next-cycle implication, disabled while in reset
`define TGP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tgp assertion failed");

`endif

// ===== rtl/tgp_pkg.sv =====
// shared types and constants for the turtle grid plotter
// no dependencies
package tgp_pkg;

  localparam int unsigned GRID_DEF      = 64;
  localparam int unsigned START_POS_DEF = 32;
  localparam int unsigned POS_W         = 6;
  localparam int unsigned ROW_W         = 64;
  localparam int unsigned STEP_W        = 8;
  localparam int unsigned OP_W          = 3;

  typedef enum logic [OP_W-1:0] {
    OP_PEN_UP   = 3'd0,
    OP_PEN_DOWN = 3'd1,
    OP_TURN_R   = 3'd2,
    OP_TURN_L   = 3'd3,
    OP_MOVE     = 3'd4,
    OP_DUMP     = 3'd5
  } op_e;

  typedef enum logic [2:0] {
    CMD_PEN_UP,
    CMD_PEN_DOWN,
    CMD_TURN_R,
    CMD_TURN_L,
    CMD_MOVE,
    CMD_DUMP,
    CMD_BAD
  } cmd_e;

  typedef enum logic [1:0] {
    HDG_EAST  = 2'd0,
    HDG_NORTH = 2'd1,
    HDG_WEST  = 2'd2,
    HDG_SOUTH = 2'd3
  } hdg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEP,
    ST_MARK,
    ST_DUMP_RD,
    ST_DUMP_OUT,
    ST_REPORT
  } state_e;

  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [STEP_W-1:0] step_count;
  } in_t;

  typedef struct packed {
    logic [POS_W-1:0] x_pos;
    logic [POS_W-1:0] y_pos;
    logic [1:0]       heading;
    logic             pen_drawing;
    logic [POS_W-1:0] row_index;
    logic [ROW_W-1:0] row_bits;
    logic             last;
    logic             bad_command;
  } out_t;

  typedef struct packed {
    cmd_e              kind;
    logic [STEP_W-1:0] steps;
  } cmd_t;

  typedef struct packed {
    logic             rd_en;
    logic [POS_W-1:0] rd_row;
    logic             wr_en;
    logic [POS_W-1:0] wr_row;
    logic [ROW_W-1:0] wr_data;
  } grid_req_t;

endpackage

// ===== rtl/turtle_grid_plotter_core.sv =====
// top level of the turtle grid plotter: command queue front, execution back
// depends on tgp_pkg, tgp_front, tgp_back (and tgp_grid below it)
//
//   channel   direction  handshake          payload
//   command   in         push / full        in_i  (tgp_pkg::in_t)
//   result    out        empty / pop        out_o (tgp_pkg::out_t)
//
// pen, turn and invalid commands go from the queue entry via the report state
// a move runs a step state per step, and a mark state after it with the pen down,
// since each marked cell is a read then a write of its grid row (one port each)
// a dump reads then outputs each row, GRID rows, paced by the registered row read
// reset clears the per-row valid bits at once, so no clearing pass is needed
// either side may stall: the two-entry queue and the result register decouple them
module turtle_grid_plotter_core #(
  parameter int unsigned GRID      = tgp_pkg::GRID_DEF,
  parameter int unsigned START_POS = tgp_pkg::START_POS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push,
  output logic          full,
  input  tgp_pkg::in_t  in_i,
  output logic          empty,
  input  logic          pop,
  output tgp_pkg::out_t out_o
);

  // decoded command handoff between the front queue and the back end
  logic          cmd_valid;
  logic          cmd_ready;
  tgp_pkg::cmd_t cmd;

  // front: classify opcodes, buffer up to two commands
  tgp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_i        (in_i),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  // back: takes one command at a time when idle, owns the grid and result register
  tgp_back #(
    .GRID      (GRID),
    .START_POS (START_POS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .empty       (empty),
    .pop         (pop),
    .out_o       (out_o)
  );

endmodule

// ===== rtl/tgp_front.sv =====
// command front end: decodes opcodes and holds them in a two-entry queue
// depends on tgp_pkg and turtle_grid_plotter_core_assert.svh
`include "turtle_grid_plotter_core_assert.svh"

module tgp_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push,
  output logic          full,
  input  tgp_pkg::in_t  in_i,
  output logic          cmd_valid_o,
  input  logic          cmd_ready_i,
  output tgp_pkg::cmd_t cmd_o
);

  tgp_pkg::cmd_t ent_q [2];
  logic          wr_ptr_q, wr_ptr_d;
  logic          rd_ptr_q, rd_ptr_d;
  logic [1:0]    count_q, count_d;
  logic          wr, rd;
  tgp_pkg::cmd_t dec;

  // classify the opcode
  always_comb begin
    dec.steps = in_i.step_count;
    case (in_i.opcode)
      tgp_pkg::OP_PEN_UP:   dec.kind = tgp_pkg::CMD_PEN_UP;
      tgp_pkg::OP_PEN_DOWN: dec.kind = tgp_pkg::CMD_PEN_DOWN;
      tgp_pkg::OP_TURN_R:   dec.kind = tgp_pkg::CMD_TURN_R;
      tgp_pkg::OP_TURN_L:   dec.kind = tgp_pkg::CMD_TURN_L;
      tgp_pkg::OP_MOVE:     dec.kind = tgp_pkg::CMD_MOVE;
      tgp_pkg::OP_DUMP:     dec.kind = tgp_pkg::CMD_DUMP;
      default:              dec.kind = tgp_pkg::CMD_BAD;
    endcase
  end

  assign full        = (count_q == 2'd2);
  assign cmd_valid_o = (count_q != 2'd0);
  assign cmd_o       = ent_q[rd_ptr_q];
  assign wr          = push && !full;
  assign rd          = cmd_valid_o && cmd_ready_i;

  always_comb begin
    wr_ptr_d = wr ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = rd ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (wr && !rd) begin
      count_d = count_q + 2'd1;
    end else if (rd && !wr) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      ent_q[wr_ptr_q] <= dec;
    end
  end

  `TGP_ASSERT_NOW(a_count_bound, 1'b1, count_q <= 2'd2)
  `TGP_ASSERT_NEXT(a_count_up, wr && !rd, count_q == $past(count_q) + 2'd1)
  `TGP_ASSERT_NEXT(a_count_down, rd && !wr, count_q == $past(count_q) - 2'd1)

endmodule

// ===== rtl/tgp_grid.sv =====
// grid memory: one row per entry, registered read, per-row valid bits
// depends on tgp_pkg
module tgp_grid #(
  parameter int unsigned GRID = tgp_pkg::GRID_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  tgp_pkg::grid_req_t          req_i,
  output logic [tgp_pkg::ROW_W-1:0]   rd_data_o
);

  localparam int unsigned IDX_W = $clog2(GRID);

  logic [tgp_pkg::ROW_W-1:0] mem_q [GRID];
  logic [tgp_pkg::ROW_W-1:0] rdata_q;
  logic [GRID-1:0]           vld_q;
  logic                      rvld_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_row[IDX_W-1:0]] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rdata_q <= mem_q[req_i.rd_row[IDX_W-1:0]];
    end
  end

  // a row never written reads as cleared
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (req_i.wr_en) begin
        vld_q[req_i.wr_row[IDX_W-1:0]] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rvld_q <= vld_q[req_i.rd_row[IDX_W-1:0]];
      end
    end
  end

  assign rd_data_o = rvld_q ? rdata_q : '0;

endmodule

// ===== rtl/tgp_back.sv =====
// command back end: turtle state, move stepping, grid dump, result register
// depends on tgp_pkg, tgp_grid and turtle_grid_plotter_core_assert.svh
`include "turtle_grid_plotter_core_assert.svh"

module tgp_back #(
  parameter int unsigned GRID      = tgp_pkg::GRID_DEF,
  parameter int unsigned START_POS = tgp_pkg::START_POS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  output logic          cmd_ready_o,
  input  tgp_pkg::cmd_t cmd_i,
  output logic          empty,
  input  logic          pop,
  output tgp_pkg::out_t out_o
);

  localparam int unsigned PW      = tgp_pkg::POS_W;
  localparam int unsigned RW      = tgp_pkg::ROW_W;
  localparam int unsigned SW      = tgp_pkg::STEP_W;
  localparam int unsigned START_C = (START_POS > GRID - 1) ? GRID - 1 : START_POS;
  localparam logic [PW-1:0] MAX_POS   = PW'(GRID - 1);
  localparam logic [PW-1:0] START     = PW'(START_C);
  localparam logic [RW-1:0] ROW_MASK  = RW'((65'd1 << GRID) - 65'd1);
  localparam logic [RW-1:0] ONE_BIT   = RW'(1);

  tgp_pkg::state_e    state_q, state_d;
  logic [PW-1:0]      x_q, x_d, y_q, y_d, row_q, row_d;
  tgp_pkg::hdg_e      hdg_q, hdg_d;
  logic               pen_q, pen_d, bad_q, bad_d;
  logic [SW-1:0]      steps_q, steps_d;
  tgp_pkg::out_t      out_q, out_d;
  logic               out_valid_q, out_valid_d;
  logic               out_ready, emit;
  logic [PW-1:0]      nx, ny;
  tgp_pkg::grid_req_t grid_req;
  logic [RW-1:0]      rd_data;

  tgp_grid #(
    .GRID (GRID)
  ) u_grid (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (grid_req),
    .rd_data_o (rd_data)
  );

  assign out_ready = !out_valid_q || pop;
  assign empty     = !out_valid_q;
  assign out_o     = out_q;

  // one unit step along the heading, held on the edge
  always_comb begin
    nx = x_q;
    ny = y_q;
    case (hdg_q)
      tgp_pkg::HDG_EAST:  if (x_q < MAX_POS) nx = x_q + PW'(1);
      tgp_pkg::HDG_NORTH: if (y_q != '0) ny = y_q - PW'(1);
      tgp_pkg::HDG_WEST:  if (x_q != '0) nx = x_q - PW'(1);
      tgp_pkg::HDG_SOUTH: if (y_q < MAX_POS) ny = y_q + PW'(1);
      default:            nx = x_q;
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      tgp_pkg::ST_IDLE: begin
        if (cmd_valid_i) begin
          case (cmd_i.kind)
            tgp_pkg::CMD_MOVE:
              state_d = (cmd_i.steps == '0) ? tgp_pkg::ST_REPORT : tgp_pkg::ST_STEP;
            tgp_pkg::CMD_DUMP: state_d = tgp_pkg::ST_DUMP_RD;
            default:           state_d = tgp_pkg::ST_REPORT;
          endcase
        end
      end
      tgp_pkg::ST_STEP: begin
        if (pen_q) begin
          state_d = tgp_pkg::ST_MARK;
        end else if (steps_q == SW'(1)) begin
          state_d = tgp_pkg::ST_REPORT;
        end
      end
      tgp_pkg::ST_MARK:
        state_d = (steps_q == '0) ? tgp_pkg::ST_REPORT : tgp_pkg::ST_STEP;
      tgp_pkg::ST_DUMP_RD: state_d = tgp_pkg::ST_DUMP_OUT;
      tgp_pkg::ST_DUMP_OUT: begin
        if (out_ready) begin
          state_d = (row_q == MAX_POS) ? tgp_pkg::ST_IDLE : tgp_pkg::ST_DUMP_RD;
        end
      end
      tgp_pkg::ST_REPORT: if (out_ready) state_d = tgp_pkg::ST_IDLE;
      default: state_d = tgp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_ready_o         = 1'b0;
    emit                = 1'b0;
    x_d                 = x_q;
    y_d                 = y_q;
    hdg_d               = hdg_q;
    pen_d               = pen_q;
    bad_d               = bad_q;
    steps_d             = steps_q;
    row_d               = row_q;
    grid_req.rd_en      = 1'b0;
    grid_req.rd_row     = row_q;
    grid_req.wr_en      = 1'b0;
    grid_req.wr_row     = y_q;
    grid_req.wr_data    = rd_data | (ONE_BIT << x_q);
    out_d.x_pos         = x_q;
    out_d.y_pos         = y_q;
    out_d.heading       = hdg_q;
    out_d.pen_drawing   = pen_q;
    out_d.row_index     = '0;
    out_d.row_bits      = '0;
    out_d.last          = 1'b1;
    out_d.bad_command   = bad_q;
    case (state_q)
      tgp_pkg::ST_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          case (cmd_i.kind)
            tgp_pkg::CMD_PEN_UP:   pen_d = 1'b0;
            tgp_pkg::CMD_PEN_DOWN: pen_d = 1'b1;
            tgp_pkg::CMD_TURN_R:   hdg_d = tgp_pkg::hdg_e'(hdg_q - 2'd1);
            tgp_pkg::CMD_TURN_L:   hdg_d = tgp_pkg::hdg_e'(hdg_q + 2'd1);
            tgp_pkg::CMD_MOVE:     steps_d = cmd_i.steps;
            tgp_pkg::CMD_DUMP:     row_d = '0;
            default:               bad_d = 1'b1;
          endcase
        end
      end
      tgp_pkg::ST_STEP: begin
        x_d             = nx;
        y_d             = ny;
        steps_d         = steps_q - SW'(1);
        grid_req.rd_en  = pen_q;
        grid_req.rd_row = ny;
      end
      tgp_pkg::ST_MARK: grid_req.wr_en = 1'b1;
      tgp_pkg::ST_DUMP_RD: grid_req.rd_en = 1'b1;
      tgp_pkg::ST_DUMP_OUT: begin
        emit            = out_ready;
        out_d.row_index = row_q;
        out_d.row_bits  = rd_data & ROW_MASK;
        out_d.last      = (row_q == MAX_POS);
        if (out_ready) begin
          row_d = row_q + PW'(1);
        end
      end
      tgp_pkg::ST_REPORT: begin
        emit = out_ready;
        if (out_ready) begin
          bad_d = 1'b0;
        end
      end
      default: emit = 1'b0;
    endcase
  end

  assign out_valid_d = emit || (out_valid_q && !pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tgp_pkg::ST_IDLE;
      x_q         <= START;
      y_q         <= START;
      hdg_q       <= tgp_pkg::HDG_EAST;
      pen_q       <= 1'b0;
      bad_q       <= 1'b0;
      steps_q     <= '0;
      row_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      x_q         <= x_d;
      y_q         <= y_d;
      hdg_q       <= hdg_d;
      pen_q       <= pen_d;
      bad_q       <= bad_d;
      steps_q     <= steps_d;
      row_q       <= row_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= out_d;
    end
  end

  `TGP_ASSERT_NOW(a_pos_in_grid, 1'b1, (x_q <= MAX_POS) && (y_q <= MAX_POS))
  `TGP_ASSERT_NOW(a_mark_after_step, state_q == tgp_pkg::ST_MARK,
                  $past(state_q) == tgp_pkg::ST_STEP)
  `TGP_ASSERT_NEXT(a_last_ends_cmd, emit && out_d.last, state_q == tgp_pkg::ST_IDLE)

endmodule

// ===== dv/testbench.sv =====
// self-checking bench for turtle_grid_plotter_core: directed command table, then random commands
// keeps its own copy of the grid and turtle to predict every result row
// depends on tgp_pkg and turtle_grid_plotter_core
module testbench;
  import tgp_pkg::*;

  localparam int unsigned HALF_PERIOD  = 6;
  localparam int unsigned RESET_CYCLES = 5;
  localparam int unsigned RANDOM_ITEMS = 306;
  localparam int unsigned CALM_TAIL    = 40;    // last random items with no idling
  localparam int unsigned PAUSE_AT     = 150;   // random item where the sender drains
  localparam int unsigned DRAIN_CYCLES = 100;
  localparam int unsigned WATCHDOG_MAX = 6000;
  localparam int unsigned PRINT_MAX    = 30;

  localparam logic [POS_W-1:0] POS_LAST  = POS_W'(GRID_DEF - 1);
  localparam logic [POS_W-1:0] POS_START =
    (START_POS_DEF > GRID_DEF - 1) ? POS_LAST : POS_W'(START_POS_DEF);

  // opcodes the block must flag as unknown
  localparam logic [OP_W-1:0] OP_BAD_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_BAD_HI = 3'd7;

  // one directed row: the command and, where typed, the single result it gives
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [STEP_W-1:0] steps;
    logic              typed;
    logic [POS_W-1:0]  x;
    logic [POS_W-1:0]  y;
    hdg_e              hdg;
    logic              pen;
    logic              bad;
  } dir_row_t;

  localparam int unsigned DIR_ROWS = 24;

  // walks the border with the pen down, then small moves and dumps
  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    '{OP_PEN_UP,   8'd0,   1'b1, 6'd32, 6'd32, HDG_EAST,  1'b0, 1'b0},
    '{OP_BAD_LO,   8'hff,  1'b1, 6'd32, 6'd32, HDG_EAST,  1'b0, 1'b1},
    '{OP_BAD_HI,   8'd0,   1'b1, 6'd32, 6'd32, HDG_EAST,  1'b0, 1'b1},
    '{OP_MOVE,     8'd0,   1'b1, 6'd32, 6'd32, HDG_EAST,  1'b0, 1'b0},
    '{OP_PEN_DOWN, 8'd0,   1'b1, 6'd32, 6'd32, HDG_EAST,  1'b1, 1'b0},
    '{OP_MOVE,     8'd255, 1'b1, 6'd63, 6'd32, HDG_EAST,  1'b1, 1'b0},
    '{OP_TURN_R,   8'd0,   1'b1, 6'd63, 6'd32, HDG_SOUTH, 1'b1, 1'b0},
    '{OP_MOVE,     8'd255, 1'b1, 6'd63, 6'd63, HDG_SOUTH, 1'b1, 1'b0},
    '{OP_TURN_R,   8'd0,   1'b1, 6'd63, 6'd63, HDG_WEST,  1'b1, 1'b0},
    '{OP_MOVE,     8'd255, 1'b1, 6'd0,  6'd63, HDG_WEST,  1'b1, 1'b0},
    '{OP_TURN_R,   8'd0,   1'b1, 6'd0,  6'd63, HDG_NORTH, 1'b1, 1'b0},
    '{OP_MOVE,     8'd255, 1'b1, 6'd0,  6'd0,  HDG_NORTH, 1'b1, 1'b0},
    '{OP_DUMP,     8'd0,   1'b0, 6'd0,  6'd0,  HDG_EAST,  1'b0, 1'b0},
    '{OP_TURN_L,   8'd0,   1'b1, 6'd0,  6'd0,  HDG_WEST,  1'b1, 1'b0},
    '{OP_MOVE,     8'd1,   1'b1, 6'd0,  6'd0,  HDG_WEST,  1'b1, 1'b0},
    '{OP_TURN_L,   8'd0,   1'b1, 6'd0,  6'd0,  HDG_SOUTH, 1'b1, 1'b0},
    '{OP_TURN_L,   8'd0,   1'b1, 6'd0,  6'd0,  HDG_EAST,  1'b1, 1'b0},
    '{OP_TURN_L,   8'd0,   1'b1, 6'd0,  6'd0,  HDG_NORTH, 1'b1, 1'b0},
    '{OP_PEN_UP,   8'haa,  1'b1, 6'd0,  6'd0,  HDG_NORTH, 1'b0, 1'b0},
    '{OP_TURN_R,   8'd0,   1'b1, 6'd0,  6'd0,  HDG_EAST,  1'b0, 1'b0},
    '{OP_MOVE,     8'd7,   1'b0, 6'd0,  6'd0,  HDG_EAST,  1'b0, 1'b0},
    '{OP_PEN_DOWN, 8'h55,  1'b0, 6'd0,  6'd0,  HDG_EAST,  1'b0, 1'b0},
    '{OP_MOVE,     8'd3,   1'b0, 6'd0,  6'd0,  HDG_EAST,  1'b0, 1'b0},
    '{OP_DUMP,     8'd0,   1'b0, 6'd0,  6'd0,  HDG_EAST,  1'b0, 1'b0}
  };

  logic clk_i = 1'b0;
  logic rst_ni;
  logic push;
  logic full;
  in_t  in_i;
  logic empty;
  logic pop;
  out_t out_o;

  // predicted plotter state
  logic [ROW_W-1:0] plot_grid [GRID_DEF];
  logic [POS_W-1:0] pos_x;
  logic [POS_W-1:0] pos_y;
  hdg_e             facing;
  logic             pen_is_down;

  out_t        pending_views[$];   // result rows still owed by the block
  int unsigned mismatch_count = 0;
  int unsigned rows_seen = 0;
  int unsigned quiet_cycles = 0;
  bit          no_idle = 1'b0;     // set for the tail of the run

  always #HALF_PERIOD clk_i = ~clk_i;

  turtle_grid_plotter_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push   (push),
    .full   (full),
    .in_i   (in_i),
    .empty  (empty),
    .pop    (pop),
    .out_o  (out_o)
  );

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= PRINT_MAX) begin
      $display("mismatch at result %0d: %s", rows_seen, msg);
    end
  endtask

  function automatic void clear_plotter();
    foreach (plot_grid[r]) plot_grid[r] = '0;
    pos_x       = POS_START;
    pos_y       = POS_START;
    facing      = HDG_EAST;
    pen_is_down = 1'b0;
  endfunction

  // result row with the current turtle fields, no dump data
  function automatic out_t turtle_view(input logic bad);
    out_t v;
    v             = '0;
    v.x_pos       = pos_x;
    v.y_pos       = pos_y;
    v.heading     = facing;
    v.pen_drawing = pen_is_down;
    v.last        = 1'b1;
    v.bad_command = bad;
    return v;
  endfunction

  // applies one command to the predicted state and queues the rows it yields
  function automatic void plot_cmd(input in_t c);
    out_t       v;
    logic [1:0] h;
    h = facing;
    case (c.opcode)
      OP_PEN_UP:   pen_is_down = 1'b0;
      OP_PEN_DOWN: pen_is_down = 1'b1;
      OP_TURN_R: begin
        h      = h + 2'd3;   // clockwise
        facing = hdg_e'(h);
      end
      OP_TURN_L: begin
        h      = h + 2'd1;
        facing = hdg_e'(h);
      end
      OP_MOVE: begin
        for (int unsigned i = 0; i < c.step_count; i++) begin
          case (facing)
            HDG_EAST:  if (pos_x < POS_LAST) pos_x++;
            HDG_NORTH: if (pos_y > 0) pos_y--;
            HDG_WEST:  if (pos_x > 0) pos_x--;
            default:   if (pos_y < POS_LAST) pos_y++;
          endcase
          // an edge cell is marked again when the step is clamped
          if (pen_is_down) plot_grid[pos_y][pos_x] = 1'b1;
        end
      end
      OP_DUMP: begin
        for (int unsigned r = 0; r < GRID_DEF; r++) begin
          v           = turtle_view(1'b0);
          v.row_index = POS_W'(r);
          v.row_bits  = plot_grid[r];
          v.last      = (r == GRID_DEF - 1);
          pending_views.push_back(v);
        end
        return;
      end
      default: begin
        pending_views.push_back(turtle_view(1'b1));
        return;
      end
    endcase
    pending_views.push_back(turtle_view(1'b0));
  endfunction

  function automatic in_t random_cmd();
    in_t         c;
    int unsigned pick;
    int unsigned span;
    pick         = $urandom_range(0, 99);
    span         = $urandom_range(0, 19);
    c.step_count = STEP_W'($urandom);   // noise unless moving
    if (pick < 40) begin
      c.opcode = OP_MOVE;
      // mostly short moves, a few long enough to hit an edge
      if (span < 14) c.step_count = STEP_W'($urandom_range(0, 15));
      else if (span < 19) c.step_count = STEP_W'($urandom_range(16, 80));
      else c.step_count = STEP_W'($urandom_range(180, 255));
    end else if (pick < 52) begin
      c.opcode = OP_PEN_DOWN;
    end else if (pick < 60) begin
      c.opcode = OP_PEN_UP;
    end else if (pick < 72) begin
      c.opcode = OP_TURN_R;
    end else if (pick < 84) begin
      c.opcode = OP_TURN_L;
    end else if (pick < 90) begin
      c.opcode = OP_DUMP;
    end else begin
      c.opcode = OP_W'($urandom_range(OP_BAD_LO, OP_BAD_HI));
    end
    return c;
  endfunction

  // holds push high until the item is taken, predicts at that edge,
  // returns at the next falling edge with push still high
  task automatic send_cmd(input in_t c, input logic typed, input out_t want);
    push <= 1'b1;
    in_i <= c;
    do @(posedge clk_i); while (full);
    plot_cmd(c);
    if (typed) begin
      // the typed row stands in for the single predicted one
      void'(pending_views.pop_back());
      pending_views.push_back(want);
    end
    @(negedge clk_i);
  endtask

  task automatic sender_gap(input int unsigned cycles);
    push <= 1'b0;
    in_i <= in_t'($urandom);
    repeat (cycles) @(negedge clk_i);
  endtask

  // sender: reset, directed table, random commands, then drain and verdict
  initial begin
    out_t want;
    in_t  c;
    push   = 1'b0;
    in_i   = '0;
    rst_ni = 1'b0;
    clear_plotter();
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (DIR_TAB[k]) begin
      c.opcode     = DIR_TAB[k].op;
      c.step_count = DIR_TAB[k].steps;
      want             = '0;
      want.x_pos       = DIR_TAB[k].x;
      want.y_pos       = DIR_TAB[k].y;
      want.heading     = DIR_TAB[k].hdg;
      want.pen_drawing = DIR_TAB[k].pen;
      want.last        = 1'b1;
      want.bad_command = DIR_TAB[k].bad;
      if ($urandom_range(0, 3) == 0) sender_gap($urandom_range(1, 15));
      send_cmd(c, DIR_TAB[k].typed, want);
    end

    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS - CALM_TAIL) no_idle = 1'b1;
      if (n == PAUSE_AT) begin
        // hold off until every owed row has come back
        push <= 1'b0;
        while (pending_views.size() != 0) @(negedge clk_i);
      end
      // a stretch in the middle with a steady sender
      if (!no_idle && !(n >= 200 && n < 240) && $urandom_range(0, 3) == 0) begin
        sender_gap($urandom_range(1, 15));
      end
      send_cmd(random_cmd(), 1'b0, '0);
    end
    push <= 1'b0;

    while (pending_views.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("[turtle_grid_plotter_core] OK");
    end else begin
      $display("[turtle_grid_plotter_core] ERROR");
    end
    $finish;
  end

  // receiver: random stall bursts, occasional calm stretches, none at the tail
  initial begin
    int unsigned stall_left;
    int unsigned calm_left;
    stall_left = 0;
    calm_left  = 0;
    pop        = 1'b0;
    forever begin
      @(negedge clk_i);
      if (calm_left > 0) calm_left--;
      if (stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else if (!no_idle && calm_left == 0 && $urandom_range(0, 19) == 0) begin
        stall_left = $urandom_range(0, 14);
        pop <= 1'b0;
      end else begin
        if (calm_left == 0 && $urandom_range(0, 99) == 0) calm_left = $urandom_range(100, 300);
        pop <= 1'b1;
      end
    end
  end

  // result check, field by field against the oldest owed row
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && pop && !empty) begin
      if (pending_views.size() == 0) begin
        report_mismatch("result with nothing pending");
      end else begin
        want = pending_views.pop_front();
        if (out_o.x_pos !== want.x_pos)
          report_mismatch($sformatf("x_pos %0d, want %0d", out_o.x_pos, want.x_pos));
        if (out_o.y_pos !== want.y_pos)
          report_mismatch($sformatf("y_pos %0d, want %0d", out_o.y_pos, want.y_pos));
        if (out_o.heading !== want.heading)
          report_mismatch($sformatf("heading %0d, want %0d", out_o.heading, want.heading));
        if (out_o.pen_drawing !== want.pen_drawing)
          report_mismatch($sformatf("pen_drawing %b, want %b",
                                    out_o.pen_drawing, want.pen_drawing));
        if (out_o.row_index !== want.row_index)
          report_mismatch($sformatf("row_index %0d, want %0d",
                                    out_o.row_index, want.row_index));
        if (out_o.row_bits !== want.row_bits)
          report_mismatch($sformatf("row_bits %h, want %h", out_o.row_bits, want.row_bits));
        if (out_o.last !== want.last)
          report_mismatch($sformatf("last %b, want %b", out_o.last, want.last));
        if (out_o.bad_command !== want.bad_command)
          report_mismatch($sformatf("bad_command %b, want %b",
                                    out_o.bad_command, want.bad_command));
      end
      rows_seen++;
    end
  end

  // watchdog: cycles in a row with no item moving on either side
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_MAX);
    $display("watchdog: no handshake for %0d cycles", WATCHDOG_MAX);
    $display("[turtle_grid_plotter_core] ERROR");
    $finish;
  end

endmodule
